>>> src/rmq_pkg.sv
// shared widths and status codes for the rotation matrix to quaternion block
package rmq_pkg;

    localparam int IN_W  = 16;
    localparam int QW_W  = 15;
    localparam int QV_W  = 16;
    localparam int ST_W  = 2;
    localparam int DIF_W = IN_W + 1;

    typedef enum logic [ST_W-1:0] {
        ST_NORMAL   = 2'd0,
        ST_IDENTITY = 2'd1,
        ST_ZERO     = 2'd2,
        ST_SAT      = 2'd3
    } status_t;

endpackage

>>> src/rmq_sqrt_cell.sv
// one digit step of the pipelined integer square root
module rmq_sqrt_cell #(
    parameter int NE  = 32,
    parameter int RW  = 16,
    parameter int RMW = 18
) (
    input  logic           aclk,
    input  logic           en,
    input  logic [NE-1:0]  n_in,
    input  logic [RW-1:0]  root_in,
    input  logic [RMW-1:0] rem_in,
    output logic [NE-1:0]  n_out,
    output logic [RW-1:0]  root_out,
    output logic [RMW-1:0] rem_out
);

    logic [RMW+1:0] t;
    logic [RMW+1:0] trial;
    logic [RMW+1:0] diff;
    logic           ge;
    logic [NE-1:0]  n_reg, n_next;
    logic [RW-1:0]  root_reg, root_next;
    logic [RMW-1:0] rem_reg, rem_next;

    always_comb begin
        t         = {rem_in, n_in[NE-1:NE-2]};
        trial     = (RMW+2)'({root_in, 2'b01});
        ge        = t >= trial;
        diff      = t - trial;
        n_next    = {n_in[NE-3:0], 2'b00};
        root_next = {root_in[RW-2:0], ge};
        rem_next  = ge ? diff[RMW-1:0] : t[RMW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg    <= n_next;
            root_reg <= root_next;
            rem_reg  <= rem_next;
        end
    end

    assign n_out    = n_reg;
    assign root_out = root_reg;
    assign rem_out  = rem_reg;

endmodule

>>> src/rmq_div_cell.sv
// one quotient bit of the pipelined restoring divider
module rmq_div_cell #(
    parameter int DW = 30,
    parameter int RW = 17
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [DW-1:0] num_in,
    input  logic [DW-1:0] q_in,
    input  logic [RW-1:0] rem_in,
    input  logic [RW-1:0] den_in,
    output logic [DW-1:0] num_out,
    output logic [DW-1:0] q_out,
    output logic [RW-1:0] rem_out,
    output logic [RW-1:0] den_out
);

    logic [RW:0]   t;
    logic [RW:0]   diff;
    logic          ge;
    logic [DW-1:0] num_reg, num_next;
    logic [DW-1:0] q_reg, q_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [RW-1:0] den_reg;

    always_comb begin
        t        = {rem_in, num_in[DW-1]};
        ge       = t >= {1'b0, den_in};
        diff     = t - {1'b0, den_in};
        num_next = {num_in[DW-2:0], 1'b0};
        q_next   = {q_in[DW-2:0], ge};
        rem_next = ge ? diff[RW-1:0] : t[RW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg <= num_next;
            q_reg   <= q_next;
            rem_reg <= rem_next;
            den_reg <= den_in;
        end
    end

    assign num_out = num_reg;
    assign q_out   = q_reg;
    assign rem_out = rem_reg;
    assign den_out = den_reg;

endmodule

>>> src/rotation_matrix_to_quaternion.sv
// rotation matrix to unit quaternion, pipelined square root and dividers
//
// channel  dir  tdata                                   tuser
// s_       in   m00..m22, 9 x 16 bits signed            -
// m_       out  q_w 15, q_x 16, q_y 16, q_z 16, pad 1   status 2
//
// one request per cycle while the output is not held; R = half the
// even-rounded width of the root argument (16 at FRAC_BITS 14)
// R square root cells then 16 + FRAC_BITS divider cells per vector lane
// the whole pipeline advances when the output register is empty or taken
// reset clears only the valid bits
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // m00 m01 m02 m10 m11 m12 m20 m21 m22
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // q_w q_x q_y q_z, zero pad
    output logic [1:0]   m_tuser    // status
);

    localparam int A_W   = ((FRAC_BITS + 1 > 18) ? FRAC_BITS + 1 : 18) + 1;
    localparam int NW    = A_W - 1 + FRAC_BITS;
    localparam int NE    = NW + (NW % 2);
    localparam int R     = NE / 2;
    localparam int RMW   = R + 2;
    localparam int WW    = R - 1;
    localparam int DEN_W = R + 1;
    localparam int DV    = IN_W + FRAC_BITS;
    localparam int LAT   = R + DV + 3;

    logic adv;
    logic [LAT-1:0] vld_reg, vld_next;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign vld_next = {vld_reg[LAT-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    // input stage
    logic signed [IN_W-1:0]  m [9];
    logic signed [A_W-1:0]   a;
    logic [A_W-2:0]          ua;
    logic [NE-1:0]           n0_next, n0_reg;
    logic signed [DIF_W-1:0] d_next [3];
    logic signed [DIF_W-1:0] d0_reg [3];

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            m[i] = s_tdata[i*IN_W +: IN_W];
        end
        a = A_W'(m[0]) + A_W'(m[4]) + A_W'(m[8]) + (A_W'(1) << FRAC_BITS);
        ua = a[A_W-1] ? '0 : a[A_W-2:0];
        n0_next = NE'({ua, {FRAC_BITS{1'b0}}});
        d_next[0] = DIF_W'(m[7]) - DIF_W'(m[5]);
        d_next[1] = DIF_W'(m[2]) - DIF_W'(m[6]);
        d_next[2] = DIF_W'(m[3]) - DIF_W'(m[1]);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            n0_reg <= n0_next;
            d0_reg <= d_next;
        end
    end

    // square root chain
    logic [NE-1:0]           sn   [R+1];
    logic [R-1:0]            sr   [R+1];
    logic [RMW-1:0]          srm  [R+1];
    logic signed [DIF_W-1:0] sd_reg [R+1][3];

    assign sn[0]  = n0_reg;
    assign sr[0]  = '0;
    assign srm[0] = '0;

    always_comb begin
        sd_reg[0] = d0_reg;
    end

    for (genvar i = 0; i < R; i++) begin : g_sqrt
        rmq_sqrt_cell #(.NE(NE), .RW(R), .RMW(RMW)) u_cell (
            .aclk     (aclk),
            .en       (adv),
            .n_in     (sn[i]),
            .root_in  (sr[i]),
            .rem_in   (srm[i]),
            .n_out    (sn[i+1]),
            .root_out (sr[i+1]),
            .rem_out  (srm[i+1])
        );
        always_ff @(posedge aclk) begin
            if (adv) begin
                sd_reg[i+1] <= sd_reg[i];
            end
        end
    end

    // classify and set up division
    localparam logic [WW:0] ONE_W = (WW+1)'(1) << FRAC_BITS;
    logic [WW-1:0]   w;
    status_t         cls_next;
    logic [DEN_W-1:0] den_next;
    logic [DV-1:0]   num_next [3];
    logic [2:0]      neg_next;

    always_comb begin
        w = sr[R][R-1:1];
        priority if ({1'b0, w} > ONE_W) begin
            cls_next = ST_IDENTITY;
        end else if (w == '0) begin
            cls_next = ST_ZERO;
        end else begin
            cls_next = ST_NORMAL;
        end
        den_next = {w, 2'b00};
        for (int k = 0; k < 3; k++) begin
            logic [DIF_W-1:0] mag;
            mag = sd_reg[R][k][DIF_W-1] ? DIF_W'(-sd_reg[R][k]) : DIF_W'(sd_reg[R][k]);
            neg_next[k] = sd_reg[R][k][DIF_W-1];
            num_next[k] = {mag[IN_W-1:0], {FRAC_BITS{1'b0}}};
        end
    end

    logic [WW-1:0]    cw_reg  [DV+1];
    status_t          ccl_reg [DV+1];
    logic [2:0]       cng_reg [DV+1];
    logic [DEN_W-1:0] cden_reg;
    logic [DV-1:0]    cnum_reg [3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            cw_reg[0]  <= w;
            ccl_reg[0] <= cls_next;
            cng_reg[0] <= neg_next;
            cden_reg   <= den_next;
            cnum_reg   <= num_next;
        end
    end

    // divider lanes
    logic [DV-1:0]    dn  [3][DV+1];
    logic [DV-1:0]    dq  [3][DV+1];
    logic [DEN_W-1:0] drm [3][DV+1];
    logic [DEN_W-1:0] ddn [3][DV+1];

    for (genvar k = 0; k < 3; k++) begin : g_lane
        assign dn[k][0]  = cnum_reg[k];
        assign dq[k][0]  = '0;
        assign drm[k][0] = '0;
        assign ddn[k][0] = cden_reg;
        for (genvar j = 0; j < DV; j++) begin : g_div
            rmq_div_cell #(.DW(DV), .RW(DEN_W)) u_cell (
                .aclk    (aclk),
                .en      (adv),
                .num_in  (dn[k][j]),
                .q_in    (dq[k][j]),
                .rem_in  (drm[k][j]),
                .den_in  (ddn[k][j]),
                .num_out (dn[k][j+1]),
                .q_out   (dq[k][j+1]),
                .rem_out (drm[k][j+1]),
                .den_out (ddn[k][j+1])
            );
        end
    end

    for (genvar j = 0; j < DV; j++) begin : g_side
        always_ff @(posedge aclk) begin
            if (adv) begin
                cw_reg[j+1]  <= cw_reg[j];
                ccl_reg[j+1] <= ccl_reg[j];
                cng_reg[j+1] <= cng_reg[j];
            end
        end
    end

    // output stage
    localparam logic [DV-1:0] ONE_Q = DV'(1) << FRAC_BITS;
    logic [QW_W-1:0] qw_next, qw_reg;
    logic [QV_W-1:0] qv_next [3];
    logic [QV_W-1:0] qv_reg [3];
    status_t         st_next, st_reg;
    logic            any_sat;

    always_comb begin
        any_sat = 1'b0;
        for (int k = 0; k < 3; k++) begin
            logic [DV-1:0] qm;
            logic [DV-1:0] sv;
            if (dq[k][DV] > ONE_Q) begin
                qm = ONE_Q;
                any_sat = 1'b1;
            end else begin
                qm = dq[k][DV];
            end
            sv = cng_reg[DV][k] ? DV'(-qm) : qm;
            qv_next[k] = sv[QV_W-1:0];
        end
        unique case (ccl_reg[DV])
            ST_IDENTITY: begin
                qw_next = ONE_Q[QW_W-1:0];
                qv_next[0] = '0;
                qv_next[1] = '0;
                qv_next[2] = '0;
                st_next = ST_IDENTITY;
            end
            ST_ZERO: begin
                qw_next = '0;
                qv_next[0] = ONE_Q[QV_W-1:0];
                qv_next[1] = '0;
                qv_next[2] = '0;
                st_next = ST_ZERO;
            end
            default: begin
                qw_next = QW_W'(cw_reg[DV]);
                st_next = any_sat ? ST_SAT : ST_NORMAL;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            qw_reg <= qw_next;
            qv_reg <= qv_next;
            st_reg <= st_next;
        end
    end

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = {1'b0, qv_reg[2], qv_reg[1], qv_reg[0], qw_reg};
    assign m_tuser  = st_reg;

    a_identity : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st_reg == ST_IDENTITY |-> qw_reg == ONE_Q[QW_W-1:0]
            && qv_reg[0] == '0 && qv_reg[1] == '0 && qv_reg[2] == '0)
        else $error("identity result not clean");

    a_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st_reg == ST_ZERO |-> qw_reg == '0)
        else $error("zero scalar with nonzero w");

    a_stall : assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg) && $stable(st_reg))
        else $error("pipeline moved while stalled");

endmodule
